@@ hw/rtl/ecms_pkg.sv @@
// ----------------------------------------------------------------------------
// ecms_pkg
// shared types and constants of the edge count-min sketch unit
// ----------------------------------------------------------------------------
`default_nettype none

package ecms_pkg;

	localparam int unsigned ROWS        = 2;
	localparam int unsigned BUCKETS     = 1024;
	localparam int unsigned BUCKET_W    = $clog2(BUCKETS);
	localparam int unsigned ROW_W       = $clog2(ROWS);
	localparam int unsigned TABLE_DEPTH = ROWS * BUCKETS;
	localparam int unsigned TBL_ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned FACTOR_W    = 17;
	localparam int unsigned FRAC_W      = 16;
	localparam int unsigned NODE_W      = 16;
	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned IN_DATA_W   = 88;
	localparam int unsigned MUL_P_W     = COUNT_W + FACTOR_W;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_DECAY  = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_NODE_MULT  = 3'd0,
		REG_ROW0_SCALE = 3'd1,
		REG_ROW0_OFFS  = 3'd2,
		REG_ROW1_SCALE = 3'd3,
		REG_ROW1_OFFS  = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_KEY,
		ST_ROW0,
		ST_ROW1,
		ST_ACC0,
		ST_ACC1,
		ST_DEC_RD
	} state_t;

	typedef struct packed {
		logic                  we;
		logic [TBL_ADDR_W-1:0] addr;
		logic [COUNT_W-1:0]    data;
	} tbl_wr_t;

	typedef struct packed {
		logic                  en;
		logic [TBL_ADDR_W-1:0] addr;
	} tbl_rd_t;

endpackage

`default_nettype wire

@@ hw/rtl/ecms_table.sv @@
// ----------------------------------------------------------------------------
// ecms_table
// bucket count memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ecms_table (
	input  wire logic                         clk,
	input  wire ecms_pkg::tbl_wr_t            wr,
	input  wire ecms_pkg::tbl_rd_t            rd,
	output logic [ecms_pkg::COUNT_W-1:0]      rd_data
);

	logic [ecms_pkg::COUNT_W-1:0] mem [ecms_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/edge_count_min_sketch_unit.sv @@
// ----------------------------------------------------------------------------
// edge_count_min_sketch_unit
// count-min sketch over graph edges with one shared multiplier
// ----------------------------------------------------------------------------
// insert and query: busy in KEY, ROW0, ROW1, ACC0, ACC1 after the transfer;
//   a query result is registered on m_tvalid at the end of ACC1, after any stall
// decay: each bucket read in DEC_RD, scaled in ACC0 through the shared multiplier
// clear: one bucket written per cycle over all 2048 buckets
// after reset a clearing pass over all 2048 buckets runs before s_tready rises;
//   configuration writes are taken at all times
`default_nettype none

module edge_count_min_sketch_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// command[1:0] src_node[17:2] dst_node[33:18] weight[65:34] decay_factor[82:66]
	input  wire logic [ecms_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// estimate[31:0]
	output logic [ecms_pkg::COUNT_W-1:0]         m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ecms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ecms_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned BW      = ecms_pkg::BUCKET_W;
	localparam int unsigned CW      = ecms_pkg::COUNT_W;
	localparam int unsigned AW      = ecms_pkg::TBL_ADDR_W;
	localparam int unsigned FW      = ecms_pkg::FACTOR_W;
	localparam int unsigned NW      = ecms_pkg::NODE_W;
	localparam int unsigned MUL_P_W = ecms_pkg::MUL_P_W;

	ecms_pkg::state_t state_q, state_d;
	ecms_pkg::cmd_t   cmd_q;

	logic [AW-1:0]        idx_q;
	logic [NW-1:0]        src_q, dst_q;
	logic [CW-1:0]        weight_q;
	logic [FW-1:0]        factor_q;
	logic [BW-1:0]        key_q, addr0_q, addr1_q;
	logic [CW-1:0]        min_q;
	logic                 out_valid_q;
	logic [CW-1:0]        out_data_q;
	logic [NW-1:0]        node_mult_q;
	logic [BW-1:0]        scale0_q, offs0_q, scale1_q, offs1_q;

	logic [CW-1:0]                 mul_a;
	logic [FW-1:0]                 mul_b;
	logic [MUL_P_W-1:0]            mul_p;
	logic [CW-1:0]                 rd_data;
	logic [CW:0]                   sum;
	logic [CW:0]                   dec;
	logic [CW-1:0]                 sat_sum, sat_dec;
	logic                          idx_last, in_xfer, out_load;
	ecms_pkg::tbl_wr_t             wr;
	ecms_pkg::tbl_rd_t             rd;

	assign in_xfer  = s_tvalid && s_tready;
	assign idx_last = (idx_q == AW'(ecms_pkg::TABLE_DEPTH - 1));
	assign out_load = (state_q == ecms_pkg::ST_ACC1) && (cmd_q == ecms_pkg::CMD_QUERY)
		&& (!out_valid_q || m_tready);

	assign s_tready  = (state_q == ecms_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// shared multiplier
	assign mul_p   = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

	assign sum     = {1'b0, rd_data} + {1'b0, weight_q};
	assign sat_sum = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
	assign dec     = mul_p[ecms_pkg::FRAC_W +: CW+1];
	assign sat_dec = dec[CW] ? {CW{1'b1}} : dec[CW-1:0];

	ecms_table u_table (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ecms_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (ecms_pkg::cmd_t'(s_tdata[1:0]))
						ecms_pkg::CMD_DECAY: state_d = ecms_pkg::ST_DEC_RD;
						ecms_pkg::CMD_CLEAR: state_d = ecms_pkg::ST_CLR;
						default:             state_d = ecms_pkg::ST_KEY;
					endcase
				end
			end
			ecms_pkg::ST_CLR:    if (idx_last) state_d = ecms_pkg::ST_IDLE;
			ecms_pkg::ST_KEY:    state_d = ecms_pkg::ST_ROW0;
			ecms_pkg::ST_ROW0:   state_d = ecms_pkg::ST_ROW1;
			ecms_pkg::ST_ROW1:   state_d = ecms_pkg::ST_ACC0;
			ecms_pkg::ST_ACC0: begin
				state_d = (cmd_q == ecms_pkg::CMD_DECAY) ?
					(idx_last ? ecms_pkg::ST_IDLE : ecms_pkg::ST_DEC_RD) : ecms_pkg::ST_ACC1;
			end
			ecms_pkg::ST_ACC1: begin
				if (cmd_q != ecms_pkg::CMD_QUERY || out_load) state_d = ecms_pkg::ST_IDLE;
			end
			ecms_pkg::ST_DEC_RD: state_d = ecms_pkg::ST_ACC0;
			default:             state_d = ecms_pkg::ST_IDLE;
		endcase
	end

	// datapath control; decay reuses the first access state for its write back
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		wr      = '0;
		rd      = '0;
		case (state_q)
			ecms_pkg::ST_CLR: begin
				wr.we   = 1'b1;
				wr.addr = idx_q;
			end
			ecms_pkg::ST_KEY: begin
				mul_a = CW'(dst_q[BW-1:0]);
				mul_b = FW'(node_mult_q[BW-1:0]);
			end
			ecms_pkg::ST_ROW0: begin
				mul_a = CW'(key_q);
				mul_b = FW'(scale0_q);
			end
			ecms_pkg::ST_ROW1: begin
				mul_a   = CW'(key_q);
				mul_b   = FW'(scale1_q);
				rd.en   = 1'b1;
				rd.addr = {1'b0, addr0_q};
			end
			ecms_pkg::ST_DEC_RD: begin
				rd.en   = 1'b1;
				rd.addr = idx_q;
			end
			ecms_pkg::ST_ACC0: begin
				if (cmd_q == ecms_pkg::CMD_DECAY) begin
					mul_a   = rd_data;
					mul_b   = factor_q;
					wr.we   = 1'b1;
					wr.addr = idx_q;
					wr.data = sat_dec;
				end else begin
					rd.en   = 1'b1;
					rd.addr = {1'b1, addr1_q};
					wr.we   = (cmd_q == ecms_pkg::CMD_INSERT);
					wr.addr = {1'b0, addr0_q};
					wr.data = sat_sum;
				end
			end
			ecms_pkg::ST_ACC1: begin
				wr.we   = (cmd_q == ecms_pkg::CMD_INSERT);
				wr.addr = {1'b1, addr1_q};
				wr.data = sat_sum;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ecms_pkg::ST_CLR;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			node_mult_q <= NW'(1);
			scale0_q    <= BW'(1);
			offs0_q     <= '0;
			scale1_q    <= BW'(3);
			offs1_q     <= BW'(7);
		end else begin
			state_q <= state_d;
			if (state_q == ecms_pkg::ST_CLR
				|| (state_q == ecms_pkg::ST_ACC0 && cmd_q == ecms_pkg::CMD_DECAY)) begin
				idx_q <= idx_q + AW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				case (ecms_pkg::reg_idx_t'(cfg_index))
					ecms_pkg::REG_NODE_MULT:  node_mult_q <= cfg_data;
					ecms_pkg::REG_ROW0_SCALE: scale0_q    <= cfg_data[BW-1:0];
					ecms_pkg::REG_ROW0_OFFS:  offs0_q     <= cfg_data[BW-1:0];
					ecms_pkg::REG_ROW1_SCALE: scale1_q    <= cfg_data[BW-1:0];
					ecms_pkg::REG_ROW1_OFFS:  offs1_q     <= cfg_data[BW-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= ecms_pkg::cmd_t'(s_tdata[1:0]);
			src_q    <= s_tdata[17:2];
			dst_q    <= s_tdata[33:18];
			weight_q <= s_tdata[65:34];
			factor_q <= s_tdata[82:66];
		end
		if (state_q == ecms_pkg::ST_KEY) begin
			key_q <= src_q[BW-1:0] + mul_p[BW-1:0];
		end
		if (state_q == ecms_pkg::ST_ROW0) begin
			addr0_q <= mul_p[BW-1:0] + offs0_q;
		end
		if (state_q == ecms_pkg::ST_ROW1) begin
			addr1_q <= mul_p[BW-1:0] + offs1_q;
		end
		if (state_q == ecms_pkg::ST_ACC0) begin
			min_q <= rd_data;
		end
		if (out_load) begin
			out_data_q <= (rd_data < min_q) ? rd_data : min_q;
		end
	end

	a_query_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ecms_pkg::ST_ACC1 && cmd_q == ecms_pkg::CMD_QUERY
			&& out_valid_q && !m_tready) |=> (state_q == ecms_pkg::ST_ACC1))
		else $error("query result dropped while output stalled");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (state_q == ecms_pkg::ST_CLR || state_q == ecms_pkg::ST_ACC0
			|| state_q == ecms_pkg::ST_ACC1))
		else $error("table written outside an access state");

	a_query_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == ecms_pkg::CMD_QUERY && state_q != ecms_pkg::ST_CLR) |-> !wr.we)
		else $error("query modified the table");

	a_sweep_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ecms_pkg::ST_CLR && idx_last) |=> (state_q == ecms_pkg::ST_IDLE))
		else $error("clear sweep did not end");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the edge count-min sketch unit: a directed table
// followed by random insert/query/decay/clear traffic over several register
// settings, with random idling on both streams and a bucket-table predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ecms_pkg::cmd_t cmd;
		logic [15:0]    src;
		logic [15:0]    dst;
		logic [31:0]    weight;
		logic [16:0]    factor;
		bit             typed;
		logic [31:0]    estimate;
	} edge_cmd_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [ecms_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [ecms_pkg::COUNT_W-1:0]    m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [ecms_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [ecms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [31:0] sketch_tbl [ecms_pkg::TABLE_DEPTH];
	logic [15:0] node_mult;
	logic [9:0]  row_scale [2];
	logic [9:0]  row_offset [2];
	logic [31:0] estimate_q [$];
	edge_cmd_t   directed_q [$];
	int          failures = 0;
	int          idle_mode = 0;
	int          hold_cycles = 0;

	edge_count_min_sketch_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int slot_of(int row, logic [15:0] src, logic [15:0] dst);
		logic [63:0] key;
		logic [63:0] h;
		key = 64'(src) + 64'(node_mult) * 64'(dst);
		h = key * 64'(row_scale[row]) + 64'(row_offset[row]);
		return row * ecms_pkg::BUCKETS + int'(h % ecms_pkg::BUCKETS);
	endfunction

	// update the sketch copy and return the estimate a query produces
	function automatic logic [31:0] sketch_apply(edge_cmd_t it);
		logic [32:0] sum;
		logic [63:0] prod;
		logic [31:0] best;
		int k;
		best = '1;
		case (it.cmd)
			ecms_pkg::CMD_INSERT: begin
				for (int r = 0; r < ecms_pkg::ROWS; r++) begin
					k = slot_of(r, it.src, it.dst);
					sum = 33'(sketch_tbl[k]) + 33'(it.weight);
					sketch_tbl[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
				end
			end
			ecms_pkg::CMD_QUERY: begin
				for (int r = 0; r < ecms_pkg::ROWS; r++) begin
					k = slot_of(r, it.src, it.dst);
					if (sketch_tbl[k] < best) best = sketch_tbl[k];
				end
			end
			ecms_pkg::CMD_DECAY: begin
				for (int j = 0; j < ecms_pkg::TABLE_DEPTH; j++) begin
					prod = (64'(sketch_tbl[j]) * 64'(it.factor)) >> ecms_pkg::FRAC_W;
					sketch_tbl[j] = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
				end
			end
			default: begin
				for (int j = 0; j < ecms_pkg::TABLE_DEPTH; j++) sketch_tbl[j] = '0;
			end
		endcase
		return best;
	endfunction

	task automatic send_cmd(edge_cmd_t it);
		logic [31:0] est;
		int gap;
		gap = (idle_mode == 0) ? 12 : (idle_mode == 1) ? 70 : 0;
		while ($urandom_range(99) < gap) @(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {5'b0, it.factor, it.weight, it.dst, it.src, it.cmd};
		do @(posedge clk); while (!s_tready);
		est = sketch_apply(it);
		if (it.cmd == ecms_pkg::CMD_QUERY) estimate_q.push_back(it.typed ? it.estimate : est);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic drain_idle();
		while (estimate_q.size() != 0) @(posedge clk);
		repeat (4400) @(posedge clk);
	endtask

	task automatic cfg_write(ecms_pkg::reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ecms_pkg::REG_NODE_MULT:  node_mult = val;
			ecms_pkg::REG_ROW0_SCALE: row_scale[0] = val[9:0];
			ecms_pkg::REG_ROW0_OFFS:  row_offset[0] = val[9:0];
			ecms_pkg::REG_ROW1_SCALE: row_scale[1] = val[9:0];
			ecms_pkg::REG_ROW1_OFFS:  row_offset[1] = val[9:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic cfg_all(logic [15:0] nm, logic [9:0] s0, logic [9:0] o0,
			logic [9:0] s1, logic [9:0] o1);
		cfg_write(ecms_pkg::REG_NODE_MULT, nm);
		cfg_write(ecms_pkg::REG_ROW0_SCALE, {6'($urandom), s0});
		cfg_write(ecms_pkg::REG_ROW0_OFFS, {6'($urandom), o0});
		cfg_write(ecms_pkg::REG_ROW1_SCALE, {6'($urandom), s1});
		cfg_write(ecms_pkg::REG_ROW1_OFFS, {6'($urandom), o1});
	endtask

	task automatic add_row(ecms_pkg::cmd_t c, logic [15:0] s, logic [15:0] d,
			logic [31:0] w, logic [16:0] f, bit typed, logic [31:0] e);
		edge_cmd_t it;
		it.cmd = c; it.src = s; it.dst = d; it.weight = w; it.factor = f;
		it.typed = typed; it.estimate = e;
		directed_q.push_back(it);
	endtask

	function automatic edge_cmd_t rand_cmd();
		edge_cmd_t it;
		int p;
		p = $urandom_range(999);
		it.cmd = (p < 450) ? ecms_pkg::CMD_INSERT : (p < 985) ? ecms_pkg::CMD_QUERY :
			(p < 993) ? ecms_pkg::CMD_DECAY : ecms_pkg::CMD_CLEAR;
		if ($urandom_range(3) != 0) begin
			it.src = 16'($urandom_range(7));
			it.dst = 16'($urandom_range(7));
		end else begin
			it.src = 16'($urandom);
			it.dst = 16'($urandom);
		end
		case ($urandom_range(3))
			0: it.weight = $urandom;
			1: it.weight = 32'hFFFF_0000 | 32'($urandom);
			default: it.weight = 32'($urandom_range(32'h0004_0000));
		endcase
		it.factor = ($urandom_range(3) == 0) ? 17'($urandom) :
			17'($urandom_range(65536, 40000));
		it.typed = 1'b0;
		it.estimate = '0;
		return it;
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= $urandom_range(99) >= ((idle_mode == 0) ? 70 :
				(idle_mode == 1) ? 12 : 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (estimate_q.size() == 0) begin
				$error("unexpected transfer, estimate actual %h", m_tdata);
				failures++;
			end else begin
				if (m_tdata !== estimate_q[0]) begin
					$error("estimate expected %h actual %h", estimate_q[0], m_tdata);
					failures++;
				end
				void'(estimate_q.pop_front());
			end
		end
	end

	initial begin
		#20ms;
		$display("FAIL edge_count_min_sketch_unit");
		$finish;
	end

	initial begin
		for (int j = 0; j < ecms_pkg::TABLE_DEPTH; j++) sketch_tbl[j] = '0;
		node_mult = 16'd1;
		row_scale[0] = 10'd1; row_offset[0] = 10'd0;
		row_scale[1] = 10'd3; row_offset[1] = 10'd7;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(ecms_pkg::CMD_QUERY, 16'h0000, 16'h0000, '0, '0, 1, 32'h0);
		add_row(ecms_pkg::CMD_QUERY, 16'hFFFF, 16'hFFFF, '0, '0, 1, 32'h0);
		add_row(ecms_pkg::CMD_INSERT, 16'h0000, 16'h0000, 32'hFFFF_FFFF, '0, 0, '0);
		add_row(ecms_pkg::CMD_INSERT, 16'h0000, 16'h0000, 32'h0000_0001, '0, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h0000, 16'h0000, '0, '0, 1, 32'hFFFF_FFFF);
		add_row(ecms_pkg::CMD_DECAY, '0, '0, '0, 17'd65536, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h0000, 16'h0000, '0, '0, 1, 32'hFFFF_FFFF);
		add_row(ecms_pkg::CMD_DECAY, '0, '0, '0, 17'h1FFFF, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h0000, 16'h0000, '0, '0, 1, 32'hFFFF_FFFF);
		add_row(ecms_pkg::CMD_DECAY, '0, '0, '0, 17'd32768, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h0000, 16'h0000, '0, '0, 1, 32'h7FFF_FFFF);
		add_row(ecms_pkg::CMD_INSERT, 16'hFFFF, 16'hFFFF, 32'h0001_8000, '0, 0, '0);
		add_row(ecms_pkg::CMD_INSERT, 16'h1234, 16'hABCD, 32'h0000_0000, '0, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'hFFFF, 16'hFFFF, '0, '0, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h1234, 16'hABCD, '0, '0, 0, '0);
		add_row(ecms_pkg::CMD_DECAY, '0, '0, '0, 17'd0, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h0000, 16'h0000, '0, '0, 1, 32'h0);
		add_row(ecms_pkg::CMD_INSERT, 16'h0005, 16'h0002, 32'h0003_0000, '0, 0, '0);
		add_row(ecms_pkg::CMD_CLEAR, '0, '0, '0, '0, 0, '0);
		add_row(ecms_pkg::CMD_QUERY, 16'h0005, 16'h0002, '0, '0, 1, 32'h0);
		foreach (directed_q[i]) send_cmd(directed_q[i]);
		drain_idle();

		// unknown indexes leave the registers alone
		cfg_write(ecms_pkg::reg_idx_t'(3'd5), 16'hFFFF);
		cfg_write(ecms_pkg::reg_idx_t'(3'd7), 16'h0000);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: cfg_all(16'hFFFF, 10'd1023, 10'd1023, 10'd1, 10'd0);
				1: cfg_all(16'h0000, 10'd0, 10'd511, 10'd1023, 10'd1023);
				2: cfg_all(16'($urandom), 10'($urandom_range(1023, 1)), 10'($urandom),
					10'($urandom_range(1023, 1)), 10'($urandom));
				default: cfg_all(16'd1, 10'd1, 10'd0, 10'd3, 10'd7);
			endcase
			idle_mode = (ph < 3) ? ph : 2;
			for (int n = 0; n < 425; n++) begin
				if (ph == 0 && n == 150) begin
					@(negedge clk);
					hold_cycles = 400;
				end
				if (ph == 1 && n == 200)
					while (estimate_q.size() != 0) @(posedge clk);
				send_cmd(rand_cmd());
			end
			drain_idle();
		end

		if (failures == 0) begin
			$display("PASS edge_count_min_sketch_unit");
		end else begin
			$display("FAIL edge_count_min_sketch_unit");
		end
		$finish;
	end

endmodule

`default_nettype wire
